// ===== hdl/csas_pkg.sv =====
// ----------------------------------------------------------------------------
// csas_pkg
// Shared types and constants for the count-smaller-after-self block.
// ----------------------------------------------------------------------------
package csas_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 6;

    // Counts saturate at the largest value the result field can carry.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] smaller_after;
        logic               last_result;
        logic               overflowed;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

// ===== hdl/count_smaller_after_self_unit.sv =====
// ----------------------------------------------------------------------------
// count_smaller_after_self_unit
// Counts, for every element of a sequence, the later elements that are
// strictly smaller, and reports all counts when the sequence ends.
// ----------------------------------------------------------------------------
// Input beats arrive on item_valid/item_ready and carry one signed value and
// a last_item mark. Result beats leave on result_valid/result_ready, one per
// stored element, in position order, with last_result on the final one.
// When an element is stored, one compare unit walks all earlier entries,
// one entry per cycle, then a drain step; no further input is taken until
// the walk is done (there is no walk when the store is empty or full).
// The walk is set by the single read port of the value and count memories.
// On a beat marked last_item the block then emits one result per stored
// entry; each result passes through memory read, output load and hand-
// over, then waits while the receiver holds result_ready low. While the
// receiver stalls the result beat is held unchanged and no input is taken.
// Elements arriving once MAX_ITEMS are stored are dropped, and every result
// of that sequence carries overflowed. After the final result the store is
// empty again. Reset empties the store and clears the overflow flag; the
// memories themselves are not cleared, only entries below the fill level
// are ever read.
// ----------------------------------------------------------------------------
module count_smaller_after_self_unit
    import csas_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int FILL_W = $clog2(MAX_ITEMS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_ITEMS);

    // Storage: one entry per element of the current sequence.
    logic signed [VALUE_W-1:0] value_mem [MAX_ITEMS];
    logic        [COUNT_W-1:0] count_mem [MAX_ITEMS];

    state_t state_reg, state_next;

    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic                      dropped_reg, dropped_next;
    logic                      last_pend_reg, last_pend_next;
    logic [IDX_W-1:0]          scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]          scan_last_reg;
    logic [IDX_W-1:0]          emit_idx_reg, emit_idx_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic                      cmp_vld_reg;
    logic [IDX_W-1:0]          cmp_idx_reg;
    logic signed [VALUE_W-1:0] value_rd_reg;
    logic [COUNT_W-1:0]        count_rd_reg;
    logic                      result_valid_reg, result_valid_next;
    result_t                   result_reg;

    // Control strobes decoded from the state.
    logic accept;
    logic scan_issue;
    logic emit_rd;
    logic emit_ld;
    logic emit_take;

    logic             full;
    logic [IDX_W-1:0] emit_last;
    logic             emit_is_last;

    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [IDX_W-1:0] cnt_raddr;
    logic [COUNT_W-1:0] cmp_count;

    assign full         = fill_reg == FILL_FULL;
    assign emit_last    = IDX_W'(fill_reg - FILL_W'(1));
    assign emit_is_last = emit_idx_reg == emit_last;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    // A stored element with predecessors needs a walk over them.
                    if (!full && (fill_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (item.last_item)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == scan_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_pend_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (result_ready)
                begin
                    state_next = emit_is_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = state_reg == ST_IDLE;
        scan_issue = state_reg == ST_SCAN;
        emit_rd    = state_reg == ST_EMIT_RD;
        emit_ld    = state_reg == ST_EMIT_LD;
        emit_take  = (state_reg == ST_EMIT_WAIT) && result_ready;
        accept     = item_valid && item_ready;
    end

    // ------------------------------------------------------------------
    // Fill level, overflow flag and walk counters
    // ------------------------------------------------------------------
    always_comb
    begin
        fill_next         = fill_reg;
        dropped_next      = dropped_reg;
        last_pend_next    = last_pend_reg;
        scan_idx_next     = scan_idx_reg;
        emit_idx_next     = emit_idx_reg;
        result_valid_next = result_valid_reg;

        if (accept)
        begin
            last_pend_next = item.last_item;
            scan_idx_next  = '0;
            emit_idx_next  = '0;
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        if (scan_issue)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        if (emit_ld)
        begin
            result_valid_next = 1'b1;
        end

        if (emit_take)
        begin
            result_valid_next = 1'b0;
            emit_idx_next     = emit_idx_reg + IDX_W'(1);
            // The final result closes the sequence.
            if (emit_is_last)
            begin
                fill_next    = '0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            dropped_reg      <= 1'b0;
            last_pend_reg    <= 1'b0;
            scan_idx_reg     <= '0;
            emit_idx_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg         <= fill_next;
            dropped_reg      <= dropped_next;
            last_pend_reg    <= last_pend_next;
            scan_idx_reg     <= scan_idx_next;
            emit_idx_reg     <= emit_idx_next;
            cmp_vld_reg      <= scan_issue;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (accept)
        begin
            key_reg       <= item.value;
            scan_last_reg <= fill_reg[IDX_W-1:0] - IDX_W'(1);
        end
        if (emit_ld)
        begin
            result_reg.position      <= POS_W'(emit_idx_reg);
            result_reg.smaller_after <= count_rd_reg;
            result_reg.last_result   <= emit_is_last;
            result_reg.overflowed    <= dropped_reg;
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write port and one registered read port each.
    // The new element is written on acceptance; the walk covers only the
    // entries stored before it, so the two writers never meet.
    // ------------------------------------------------------------------
    assign cnt_we    = (accept && !full) || cmp_vld_reg;
    assign cnt_waddr = cmp_vld_reg ? cmp_idx_reg : fill_reg[IDX_W-1:0];
    assign cnt_wdata = cmp_vld_reg ? cmp_count : '0;
    assign cnt_raddr = emit_rd ? emit_idx_reg : scan_idx_reg;

    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            value_mem[fill_reg[IDX_W-1:0]] <= item.value;
        end
        value_rd_reg <= value_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        count_rd_reg <= count_mem[cnt_raddr];
    end

    // One compare unit, fed one stored entry per cycle during the walk.
    csas_cmp u_cmp
    (
        .stored_value (value_rd_reg),
        .stored_count (count_rd_reg),
        .key          (key_reg),
        .count_out    (cmp_count)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/csas_cmp.sv =====
// ----------------------------------------------------------------------------
// csas_cmp
// Shared compare-and-increment unit, applied to one stored entry per cycle.
// ----------------------------------------------------------------------------
module csas_cmp
    import csas_pkg::*;
(
    input  logic signed [VALUE_W-1:0] stored_value,
    input  logic        [COUNT_W-1:0] stored_count,
    input  logic signed [VALUE_W-1:0] key,
    output logic        [COUNT_W-1:0] count_out
);

    logic greater;

    // The stored entry gains one when the new value is strictly below it.
    assign greater = stored_value > key;

    always_comb
    begin
        if (greater && (stored_count != COUNT_MAX))
        begin
            count_out = stored_count + COUNT_W'(1);
        end
        else
        begin
            count_out = stored_count;
        end
    end

endmodule

// ===== hdl/csas_checker.sv =====
// ----------------------------------------------------------------------------
// csas_checker
// Port-level checks for the count-smaller-after-self block.
// ----------------------------------------------------------------------------
module csas_checker
    import csas_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // An input beat that is refused stays offered, unchanged.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("input beat withdrawn or changed while refused");

    // A result beat that is not taken stays, unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // Emission and intake never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
    else $error("input accepted while a result is pending");

    // Nothing follows the final result of a sequence directly.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_result |=> !result_valid)
    else $error("result presented straight after the final one");

    // The overflow mark is the same on consecutive results of a sequence.
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_result
        |=> ##2 result_valid && (result.overflowed == $past(result.overflowed, 3)))
    else $error("overflow mark changed within a sequence");

endmodule

bind count_smaller_after_self_unit csas_checker u_csas_checker (.*);
